>>> hw/rtl/tts_pkg.sv
// Package for the timer table scheduler: widths, codes, entry and result types.
// No dependencies.
`default_nettype none
package tts_pkg;
  localparam int Capacity = 32;
  localparam int MaxResults = 32;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = 7;
  localparam int TimeW = 63;
  localparam int EmitW = $clog2(MaxResults + 1);

  localparam logic [2:0] OP_SCHED = 3'd0;
  localparam logic [2:0] OP_CANCEL = 3'd1;
  localparam logic [2:0] OP_CANCEL_ALL = 3'd2;
  localparam logic [2:0] OP_EXPIRE = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_EXPIRED = 3'd3;
  localparam logic [2:0] ST_NONE_DUE = 3'd4;
  localparam logic [2:0] ST_NEXT = 3'd5;
  localparam logic [2:0] ST_EMPTY = 3'd6;

  typedef struct packed {
    logic [TimeW-1:0] tm;
    logic [31:0] src;
    logic [15:0] own;
    logic signed [31:0] id;
  } entry_t;

  typedef struct packed {
    logic [2:0] operation;
    logic [31:0] source_addr;
    logic [15:0] owner_handle;
    logic signed [31:0] timer_id;
    logic [TimeW-1:0] time_value;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [31:0] out_source;
    logic [15:0] out_owner;
    logic signed [31:0] out_id;
    logic [TimeW-1:0] out_time;
    logic [CntW-1:0] removed_count;
    logic last;
  } rsp_t;

  // ordering for expire: time, then signed id
  function automatic logic earlier(entry_t a, entry_t b);
    if (a.tm != b.tm) return a.tm < b.tm;
    return a.id < b.id;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/tts_if.sv
// Valid/ready channel interfaces for the scheduler.
// Depends on tts_pkg.
`default_nettype none
interface tts_req_if (input wire logic clk);
  logic valid;
  logic ready;
  tts_pkg::req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tts_rsp_if (input wire logic clk);
  logic valid;
  logic ready;
  tts_pkg::rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/tts_mem.sv
// Entry table: one write port, one registered read port.
// Depends on tts_pkg.
`default_nettype none
module tts_mem (
  input  wire logic clk,
  input  wire logic we,
  input  wire logic [tts_pkg::IdxW-1:0] waddr,
  input  wire tts_pkg::entry_t wdata,
  input  wire logic [tts_pkg::IdxW-1:0] raddr,
  output tts_pkg::entry_t rdata
);
  tts_pkg::entry_t mem [tts_pkg::Capacity];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

>>> hw/rtl/timer_table_scheduler_top.sv
// Timer table scheduler top: sequencer that scans the entry table memory.
// Depends on tts_pkg, tts_if, tts_mem.
//
//  channel | dir | beat contents
//  in_     | in  | operation, source, owner, id, time
//  out_    | out | status, entry fields, removed_count, last
//
// One item at a time: input ready is low from accept until the item's last
// result beat has left the output register. Table reads are registered.
//   schedule: the write happens at accept.
//   cancel miss / cancel-all without removals / query: one full scan.
//   cancel hit: scan to the hit, then move the last slot into it;
//   cancel-all does so for each removal, rescanning from the hole.
//   expire: per expired entry scan, pick, move last slot into the hole;
//   each beat is held until the next scan decides last, plus a final scan.
// Reset clears state, entry count and valid flags; table contents are undefined.
// A stalled result holds the sequencer before its next beat.
`default_nettype none
module timer_table_scheduler_top (
  input wire logic clk,
  input wire logic rst_n,
  tts_req_if.sink in_ch,
  tts_rsp_if.source out_ch
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_SCAN = 5'b00010, S_MOVE = 5'b00100,
    S_MOVEW = 5'b01000, S_DONE = 5'b10000
  } state_t;

  state_t st_r, st_nxt;
  tts_pkg::req_t req_r, req_nxt;
  logic [tts_pkg::CntW-1:0] cnt_r, cnt_nxt, rem_r, rem_nxt;
  logic [tts_pkg::CntW-1:0] ptr_r, ptr_nxt;   // next address issued
  logic rv_r, rv_nxt;                         // read data valid this cycle
  logic [tts_pkg::IdxW-1:0] rix_r, rix_nxt;   // address of the data in rdata
  logic found_r, found_nxt;
  logic [tts_pkg::IdxW-1:0] best_r, best_nxt;
  tts_pkg::entry_t best_e_r, best_e_nxt;
  logic pend_r, pend_nxt;                     // expired entry held for its beat
  tts_pkg::entry_t pend_e_r, pend_e_nxt;
  logic [tts_pkg::EmitW-1:0] ntake_r, ntake_nxt;
  logic [tts_pkg::IdxW-1:0] hole_r, hole_nxt;
  logic ovalid_r, ovalid_nxt;
  tts_pkg::rsp_t odata_r, odata_nxt;

  logic we;
  logic [tts_pkg::IdxW-1:0] waddr, raddr;
  tts_pkg::entry_t wdata, rdata;

  tts_mem u_mem (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
                 .raddr(raddr), .rdata(rdata));

  assign in_ch.ready = (st_r == S_IDLE) && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.data = odata_r;

  wire logic accept = in_ch.valid && in_ch.ready;
  wire logic out_free = !ovalid_r || out_ch.ready;
  wire logic scan_end = (ptr_r >= cnt_r) && !rv_r;
  wire logic [tts_pkg::IdxW-1:0] last_ix = tts_pkg::IdxW'(cnt_r - 7'd1);
  // expire: another due entry is waiting and the beat limit allows it
  wire logic more = found_r && (ntake_r < tts_pkg::EmitW'(tts_pkg::MaxResults));

  // hit on the current read beat, per operation
  logic hit;
  always_comb begin
    case (req_r.operation)
      tts_pkg::OP_CANCEL: hit = rdata.src == req_r.source_addr &&
                            rdata.own == req_r.owner_handle && rdata.id == req_r.timer_id;
      tts_pkg::OP_CANCEL_ALL: hit = rdata.src == req_r.source_addr;
      tts_pkg::OP_EXPIRE: hit = rdata.tm <= req_r.time_value &&
                            (!found_r || tts_pkg::earlier(rdata, best_e_r));
      tts_pkg::OP_QUERY: hit = !found_r || rdata.tm < best_e_r.tm;
      default: hit = 1'b0;
    endcase
  end

  always_comb begin
    we = 1'b0;
    waddr = hole_r;
    wdata = rdata;
    raddr = ptr_r[tts_pkg::IdxW-1:0];
    if (st_r == S_IDLE) begin
      waddr = tts_pkg::IdxW'(cnt_r);
      wdata.tm = in_ch.data.time_value;
      wdata.src = in_ch.data.source_addr;
      wdata.own = in_ch.data.owner_handle;
      wdata.id = in_ch.data.timer_id;
      we = accept && in_ch.data.operation == tts_pkg::OP_SCHED &&
           cnt_r < 7'(tts_pkg::Capacity);
      raddr = '0;
    end else if (st_r == S_MOVE) begin
      raddr = last_ix;
    end else if (st_r == S_MOVEW) begin
      we = 1'b1;
    end
  end

  always_comb begin
    st_nxt = st_r;
    req_nxt = req_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    ptr_nxt = ptr_r;
    rv_nxt = rv_r;
    rix_nxt = rix_r;
    found_nxt = found_r;
    best_nxt = best_r;
    best_e_nxt = best_e_r;
    pend_nxt = pend_r;
    pend_e_nxt = pend_e_r;
    ntake_nxt = ntake_r;
    hole_nxt = hole_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    odata_nxt = odata_r;
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          req_nxt = in_ch.data;
          ptr_nxt = '0;
          rv_nxt = 1'b0;
          found_nxt = 1'b0;
          rem_nxt = '0;
          pend_nxt = 1'b0;
          ntake_nxt = '0;
          case (in_ch.data.operation)
            tts_pkg::OP_SCHED: begin
              ovalid_nxt = 1'b1;
              odata_nxt = '0;
              odata_nxt.last = 1'b1;
              if (cnt_r < 7'(tts_pkg::Capacity)) begin
                cnt_nxt = cnt_r + 7'd1;
                odata_nxt.status = tts_pkg::ST_OK;
              end else begin
                odata_nxt.status = tts_pkg::ST_FULL;
              end
            end
            tts_pkg::OP_CANCEL, tts_pkg::OP_CANCEL_ALL, tts_pkg::OP_EXPIRE,
            tts_pkg::OP_QUERY: st_nxt = S_SCAN;
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (rv_r && hit) begin
          found_nxt = 1'b1;
          best_nxt = rix_r;
          best_e_nxt = rdata;
        end
        if (rv_r && hit && (req_r.operation == tts_pkg::OP_CANCEL ||
                            req_r.operation == tts_pkg::OP_CANCEL_ALL)) begin
          // remove this slot: move the last entry into it
          hole_nxt = rix_r;
          rv_nxt = 1'b0;
          ptr_nxt = tts_pkg::CntW'(rix_r);
          rem_nxt = rem_r + 7'd1;
          st_nxt = S_MOVE;
        end else if (scan_end) begin
          st_nxt = S_DONE;
        end else begin
          rv_nxt = ptr_r < cnt_r;
          rix_nxt = ptr_r[tts_pkg::IdxW-1:0];
          if (ptr_r < cnt_r) ptr_nxt = ptr_r + 7'd1;
        end
      end
      S_MOVE: begin
        cnt_nxt = cnt_r - 7'd1;
        st_nxt = S_MOVEW;
      end
      S_MOVEW: begin
        case (req_r.operation)
          tts_pkg::OP_CANCEL: st_nxt = S_DONE;
          tts_pkg::OP_CANCEL_ALL: st_nxt = S_SCAN;   // rescan from the hole
          default: begin                              // expire: full rescan
            st_nxt = S_SCAN;
            ptr_nxt = '0;
            rv_nxt = 1'b0;
            found_nxt = 1'b0;
          end
        endcase
      end
      S_DONE: begin
        case (req_r.operation)
          tts_pkg::OP_CANCEL: begin
            if (out_free) begin
              ovalid_nxt = 1'b1;
              odata_nxt = '0;
              odata_nxt.status = (rem_r != 0) ? tts_pkg::ST_OK : tts_pkg::ST_NOT_FOUND;
              odata_nxt.last = 1'b1;
              st_nxt = S_IDLE;
            end
          end
          tts_pkg::OP_CANCEL_ALL: begin
            if (out_free) begin
              ovalid_nxt = 1'b1;
              odata_nxt = '0;
              odata_nxt.status = tts_pkg::ST_OK;
              odata_nxt.removed_count = rem_r;
              odata_nxt.last = 1'b1;
              st_nxt = S_IDLE;
            end
          end
          tts_pkg::OP_QUERY: begin
            if (out_free) begin
              ovalid_nxt = 1'b1;
              odata_nxt = '0;
              odata_nxt.status = found_r ? tts_pkg::ST_NEXT : tts_pkg::ST_EMPTY;
              odata_nxt.out_time = found_r ? best_e_r.tm : '0;
              odata_nxt.last = 1'b1;
              st_nxt = S_IDLE;
            end
          end
          default: begin // expire
            if (pend_r) begin
              // the held entry goes out now; this scan tells whether it is last
              if (out_free) begin
                ovalid_nxt = 1'b1;
                odata_nxt = '0;
                odata_nxt.status = tts_pkg::ST_EXPIRED;
                odata_nxt.out_source = pend_e_r.src;
                odata_nxt.out_owner = pend_e_r.own;
                odata_nxt.out_id = pend_e_r.id;
                odata_nxt.out_time = pend_e_r.tm;
                odata_nxt.last = !more;
                if (more) begin
                  pend_e_nxt = best_e_r;
                  hole_nxt = best_r;
                  ntake_nxt = ntake_r + 1'b1;
                  st_nxt = S_MOVE;
                end else begin
                  st_nxt = S_IDLE;
                end
              end
            end else if (found_r) begin
              pend_nxt = 1'b1;
              pend_e_nxt = best_e_r;
              hole_nxt = best_r;
              ntake_nxt = ntake_r + 1'b1;
              st_nxt = S_MOVE;
            end else if (out_free) begin
              ovalid_nxt = 1'b1;
              odata_nxt = '0;
              odata_nxt.status = tts_pkg::ST_NONE_DUE;
              odata_nxt.last = 1'b1;
              st_nxt = S_IDLE;
            end
          end
        endcase
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      ovalid_r <= 1'b0;
      rv_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      rv_r <= rv_nxt;
    end
    req_r <= req_nxt;
    rem_r <= rem_nxt;
    ptr_r <= ptr_nxt;
    rix_r <= rix_nxt;
    found_r <= found_nxt;
    best_r <= best_nxt;
    best_e_r <= best_e_nxt;
    pend_r <= pend_nxt;
    pend_e_r <= pend_e_nxt;
    ntake_r <= ntake_nxt;
    hole_r <= hole_nxt;
    odata_r <= odata_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 7'(tts_pkg::Capacity))
    else $error("entry count above capacity");
  assert property (@(posedge clk) disable iff (!rst_n) ovalid_r && !out_ch.ready |=> ovalid_r)
    else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
                   ovalid_r && !out_ch.ready |=> $stable(odata_r))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (!rst_n) accept |-> !ovalid_r)
    else $error("accepted while result pending");
  assert property (@(posedge clk) disable iff (!rst_n) $onehot(st_r))
    else $error("state not one-hot");
endmodule
`default_nettype wire

>>> tb/tts_tb_if.sv
`timescale 1ns / 1ps
// Testbench-side notes for the scheduler channels.
// The channel interfaces themselves come from the RTL (tts_if.sv); depends on tts_pkg.
package tts_tb_pkg;
  import tts_pkg::*;
  // one pending timer as the testbench tracks it
  typedef struct {
    logic [TimeW-1:0] tm;
    logic [31:0] src;
    logic [15:0] own;
    logic signed [31:0] id;
  } timer_rec_t;
endpackage

>>> tb/timer_table_scheduler_top_test.sv
`timescale 1ns / 1ps
// Testbench for timer_table_scheduler_top: directed then random operations,
// results checked against an in-bench timer table predictor. Depends on tts_pkg, tts_if.
module timer_table_scheduler_top_test;
  import tts_pkg::*;
  import tts_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  tts_req_if in_ch (clk);
  tts_rsp_if out_ch (clk);

  timer_table_scheduler_top uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  initial begin
    forever #10 clk = ~clk;
  end

  // predictor state: mirror of the timer table
  timer_rec_t timers[$];
  req_t pending_reqs[$];     // beats waiting to be driven
  rsp_t expected_rsps[$];    // results the block still owes
  int errors = 0;
  bit stim_done = 0;
  bit press_go = 0;          // stimulus asks for the long receiver stall
  bit hold_on = 0;           // long receiver stall in progress
  bit in_fire = 0;           // input beat accepted at the last rising edge
  int gap_left = 0;
  int burst_left = 0;

  task automatic report(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic rsp_t blank_rsp(input logic [2:0] st);
    rsp_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  // drop slot k, refilling it from the last slot
  function automatic void free_slot(input int k);
    timers[k] = timers[timers.size() - 1];
    void'(timers.pop_back());
  endfunction

  // apply one accepted beat to the table and queue its results
  function automatic void predict_timers(input req_t q);
    rsp_t r;
    int best, n, removed;
    bit hit;
    case (q.operation)
      OP_SCHED: begin
        if (timers.size() >= Capacity) expected_rsps.push_back(blank_rsp(ST_FULL));
        else begin
          timers.push_back('{q.time_value, q.source_addr, q.owner_handle, q.timer_id});
          expected_rsps.push_back(blank_rsp(ST_OK));
        end
      end
      OP_CANCEL: begin
        hit = 0;
        for (int i = 0; i < timers.size() && !hit; i++) begin
          if (timers[i].src == q.source_addr && timers[i].own == q.owner_handle &&
              timers[i].id == q.timer_id) begin
            free_slot(i);
            hit = 1;
          end
        end
        expected_rsps.push_back(blank_rsp(hit ? ST_OK : ST_NOT_FOUND));
      end
      OP_CANCEL_ALL: begin
        removed = 0;
        for (int i = 0; i < timers.size(); ) begin
          if (timers[i].src == q.source_addr) begin
            free_slot(i);
            removed++;
          end else i++;
        end
        r = blank_rsp(ST_OK);
        r.removed_count = removed[CntW-1:0];
        expected_rsps.push_back(r);
      end
      OP_EXPIRE: begin
        n = 0;
        while (n < MaxResults) begin
          best = -1;
          for (int i = 0; i < timers.size(); i++) begin
            if (timers[i].tm <= q.time_value) begin
              if (best < 0 || timers[i].tm < timers[best].tm ||
                  (timers[i].tm == timers[best].tm && timers[i].id < timers[best].id))
                best = i;
            end
          end
          if (best < 0) break;
          r = '0;
          r.status = ST_EXPIRED;
          r.out_source = timers[best].src;
          r.out_owner = timers[best].own;
          r.out_id = timers[best].id;
          r.out_time = timers[best].tm;
          expected_rsps.push_back(r);
          free_slot(best);
          n++;
        end
        if (n == 0) expected_rsps.push_back(blank_rsp(ST_NONE_DUE));
        else expected_rsps[expected_rsps.size() - 1].last = 1'b1;
      end
      OP_QUERY: begin
        if (timers.size() == 0) expected_rsps.push_back(blank_rsp(ST_EMPTY));
        else begin
          r = blank_rsp(ST_NEXT);
          r.out_time = timers[0].tm;
          foreach (timers[i]) if (timers[i].tm < r.out_time) r.out_time = timers[i].tm;
          expected_rsps.push_back(r);
        end
      end
      default: ;  // undefined codes: no result, no change
    endcase
  endfunction

  // ---- driver: falls on negedge, bursts with random gaps ----
  always @(negedge clk) begin
    if (rst_n) begin
      // a new beat only once the current one was taken
      if (!in_ch.valid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= pending_reqs.pop_front();
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else in_ch.valid <= 1'b0;
      end
      // receiver: long hold-off when asked, otherwise its own stall pattern
      if (hold_on) out_ch.ready <= 1'b0;
      else if ($urandom_range(0, 99) < 25) out_ch.ready <= ($urandom_range(0, 3) == 0);
      else out_ch.ready <= 1'b1;
    end else begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      out_ch.ready <= 1'b0;
    end
  end

  // ---- long receiver stall, counted here ----
  initial begin
    wait (press_go);
    @(negedge clk);
    hold_on = 1'b1;  // receiver stops; input must back up
    repeat (400) @(negedge clk);
    hold_on = 1'b0;
  end

  // ---- monitor: samples on rising edge ----
  always @(posedge clk) begin
    rsp_t want;
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) predict_timers(in_ch.data);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rsps.size() == 0) report("result with nothing expected");
        else begin
          want = expected_rsps.pop_front();
          if (out_ch.data.status !== want.status)
            report($sformatf("status %0d want %0d", out_ch.data.status, want.status));
          if (out_ch.data.out_source !== want.out_source)
            report($sformatf("source %h want %h", out_ch.data.out_source, want.out_source));
          if (out_ch.data.out_owner !== want.out_owner)
            report($sformatf("owner %h want %h", out_ch.data.out_owner, want.out_owner));
          if (out_ch.data.out_id !== want.out_id)
            report($sformatf("id %0d want %0d", out_ch.data.out_id, want.out_id));
          if (out_ch.data.out_time !== want.out_time)
            report($sformatf("time %0d want %0d", out_ch.data.out_time, want.out_time));
          if (out_ch.data.removed_count !== want.removed_count)
            report($sformatf("removed %0d want %0d", out_ch.data.removed_count,
                             want.removed_count));
          if (out_ch.data.last !== want.last)
            report($sformatf("last %b want %b", out_ch.data.last, want.last));
        end
      end
    end
  end

  // ---- stimulus ----
  // small pools of keys so cancels and ties actually hit
  logic [31:0] src_pool[4] = '{32'h0, 32'hFFFF_FFFF, 32'hC0A8_0001, 32'h0A00_0002};

  function automatic req_t mk(input logic [2:0] op, input logic [31:0] s, input logic [15:0] o,
                              input logic signed [31:0] id, input logic [TimeW-1:0] t);
    req_t q;
    q.operation = op;
    q.source_addr = s;
    q.owner_handle = o;
    q.timer_id = id;
    q.time_value = t;
    return q;
  endfunction

  function automatic logic [TimeW-1:0] rand_time();
    case ($urandom_range(0, 3))
      0: return TimeW'({$urandom, $urandom} >> 1);  // anywhere, all bits toggle
      default: return TimeW'($urandom_range(0, 200));
    endcase
  endfunction

  function automatic req_t rand_req();
    logic [31:0] s;
    logic [15:0] o;
    logic signed [31:0] id;
    int pick;
    s = ($urandom_range(0, 3) == 0) ? $urandom : src_pool[$urandom_range(0, 3)];
    o = 16'(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 3));
    id = ($urandom_range(0, 3) == 0) ? $urandom : $signed($urandom_range(0, 6)) - 3;
    pick = $urandom_range(0, 99);
    if (pick < 45) return mk(OP_SCHED, s, o, id, rand_time());
    if (pick < 62) return mk(OP_CANCEL, s, o, id, TimeW'($urandom));
    if (pick < 70) return mk(OP_CANCEL_ALL, s, o, id, TimeW'($urandom));
    if (pick < 86) return mk(OP_EXPIRE, s, o, id, rand_time());
    if (pick < 97) return mk(OP_QUERY, s, o, id, rand_time());
    return mk(3'($urandom_range(5, 7)), s, o, id, rand_time());
  endfunction

  localparam logic [TimeW-1:0] TMAX = {TimeW{1'b1}};

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // directed: empty cases, extremes, ties, full table, cancels
    pending_reqs.push_back(mk(OP_QUERY, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_EXPIRE, 0, 0, 0, TMAX));
    pending_reqs.push_back(mk(OP_CANCEL, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_CANCEL_ALL, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_SCHED, 32'hFFFF_FFFF, 16'hFFFF, 32'sh7FFF_FFFF, TMAX));
    pending_reqs.push_back(mk(OP_SCHED, 0, 0, 32'sh8000_0000, 0));
    pending_reqs.push_back(mk(OP_SCHED, 1, 1, 5, 7));
    pending_reqs.push_back(mk(OP_SCHED, 1, 1, -5, 7));   // same time, smaller id
    pending_reqs.push_back(mk(OP_SCHED, 1, 2, -5, 7));   // full tie goes to lower slot
    pending_reqs.push_back(mk(OP_QUERY, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_CANCEL, 1, 1, 5, 0));
    pending_reqs.push_back(mk(OP_CANCEL, 1, 1, 5, 0));   // now absent
    pending_reqs.push_back(mk(3'd6, 0, 0, 0, 0));
    pending_reqs.push_back(mk(OP_EXPIRE, 0, 0, 0, 7));
    pending_reqs.push_back(mk(OP_CANCEL_ALL, 32'hFFFF_FFFF, 0, 0, 0));
    // fill past capacity, cancel one source, then expire at time 3
    for (int i = 0; i < Capacity + 2; i++)
      pending_reqs.push_back(mk(OP_SCHED, src_pool[i % 4], 16'(i), 32'(i % 5), 3));
    pending_reqs.push_back(mk(OP_CANCEL_ALL, src_pool[1], 0, 0, 0));
    pending_reqs.push_back(mk(OP_EXPIRE, 0, 0, 0, 3));
    // random phase
    for (int i = 0; i < 180; i++) begin
      if ($urandom_range(0, 29) == 0) begin
        // schedule a batch then a big expire: long result trains
        repeat ($urandom_range(8, 34))
          pending_reqs.push_back(mk(OP_SCHED, $urandom, 16'($urandom), $urandom,
                                    rand_time()));
        pending_reqs.push_back(mk(OP_EXPIRE, 0, 0, 0, TMAX));
      end
      pending_reqs.push_back(rand_req());
      if (i == 120) begin
        wait (pending_reqs.size() < 10);
        press_go = 1'b1;
      end
    end
    wait (pending_reqs.size() == 0 && !in_ch.valid);
    wait (expected_rsps.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #100ms;
    $display("Some tests failed");
    $finish;
  end
endmodule
